@@ rtl/tsfh_pkg.sv @@
// Package for the tunnel slot frame handler: widths, status and emit codes,
// request and response structs and the controller command struct. No dependencies.
`default_nettype none
package tsfh_pkg;
   localparam int SLOTS = 16;
   localparam int SLOT_W = 4;
   localparam int FILL_W = 19;
   localparam logic [FILL_W-1:0] BUFFER_BYTES = 19'd262144;
   localparam logic [11:0] MAX_PAYLOAD = 12'd1024;
   localparam logic [11:0] PREFIX_BYTES = 12'd2;
   localparam logic [FILL_W-1:0] HIGH_RESET = 19'd65536;
   localparam logic [FILL_W-1:0] LOW_RESET = 19'd16384;

   localparam logic [1:0] CSR_MODE = 2'd0;
   localparam logic [1:0] CSR_HIGH = 2'd1;
   localparam logic [1:0] CSR_LOW  = 2'd2;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_LISTEN = 2'd2;

   localparam logic [1:0] CMD_FRAME = 2'd0;
   localparam logic [1:0] CMD_ACCEPT = 2'd1;
   localparam logic [1:0] CMD_DRAIN = 2'd2;

   localparam logic [2:0] FT_OPEN = 3'd0;
   localparam logic [2:0] FT_DATA = 3'd1;
   localparam logic [2:0] FT_CLOSE = 3'd2;
   localparam logic [2:0] FT_PAUSE = 3'd3;
   localparam logic [2:0] FT_RESUME = 3'd4;

   localparam logic [3:0] ST_OK = 4'd0;
   localparam logic [3:0] ST_NO_MODE = 4'd1;
   localparam logic [3:0] ST_BAD_LEN = 4'd2;
   localparam logic [3:0] ST_ZERO_GEN = 4'd3;
   localparam logic [3:0] ST_BAD_SLOT = 4'd4;
   localparam logic [3:0] ST_CTRL_DATA = 4'd5;
   localparam logic [3:0] ST_OPEN_LISTEN = 4'd6;
   localparam logic [3:0] ST_DUP_OPEN = 4'd7;
   localparam logic [3:0] ST_OVERFLOW = 4'd8;
   localparam logic [3:0] ST_QUEUE = 4'd9;
   localparam logic [3:0] ST_UNKNOWN = 4'd10;
   localparam logic [3:0] ST_LINK_DOWN = 4'd11;

   localparam logic [2:0] EM_NONE = 3'd0;
   localparam logic [2:0] EM_OPEN = 3'd1;
   localparam logic [2:0] EM_CLOSE = 3'd2;
   localparam logic [2:0] EM_PAUSE = 3'd3;
   localparam logic [2:0] EM_RESUME = 3'd4;

   typedef struct packed {
      logic [1:0]  command;
      logic [2:0]  frame_type;
      logic [7:0]  slot;
      logic [7:0]  generation;
      logic [11:0] frame_len;
      logic        connect_ok;
      logic        queue_accepts;
      logic [18:0] drained_before;
      logic [18:0] drained_after;
      logic        fail_before;
      logic        fail_after;
      logic        link_up;
   } req_type;

   typedef struct packed {
      logic [3:0] status;
      logic [2:0] emit_kind;
      logic [3:0] emit_slot;
      logic [7:0] emit_gen;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;  // load request register
      logic execute;  // apply request to table, load result register
   } cmd_type;
endpackage
`default_nettype wire

@@ rtl/tsfh_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on tsfh_pkg.
`default_nettype none
interface tsfh_req_if;
   logic valid;
   logic ready;
   tsfh_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tsfh_rsp_if;
   logic valid;
   logic ready;
   tsfh_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/tsfh_ctrl.sv @@
// Controller: sequences capture, execute and result hand-off.
// Depends on tsfh_pkg.
`default_nettype none
module tsfh_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output tsfh_pkg::cmd_type cmd
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_OUT  = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

@@ rtl/tsfh_datapath.sv @@
// Datapath: slot table, configuration registers and request evaluation.
// Depends on tsfh_pkg.
`default_nettype none
module tsfh_datapath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [18:0] csr_data,
   input  wire tsfh_pkg::cmd_type cmd,
   input  wire tsfh_pkg::req_type req_payload,
   output tsfh_pkg::rsp_type rsp_payload
);
   localparam int SW = tsfh_pkg::SLOT_W;
   localparam int FW = tsfh_pkg::FILL_W;

   logic [1:0]    mode_ff;
   logic [FW-1:0] high_ff, low_ff;
   tsfh_pkg::req_type r_ff;
   tsfh_pkg::rsp_type out_ff, res;

   logic [tsfh_pkg::SLOTS-1:0] open_ff, open_in, rp_ff, rp_in, ps_ff, ps_in;
   logic [7:0]    gen_ff [tsfh_pkg::SLOTS];
   logic [FW-1:0] fill_ff [tsfh_pkg::SLOTS];
   logic [7:0]    gen_in;
   logic [FW-1:0] fill_in;
   logic          wr_gen, wr_fill;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= tsfh_pkg::MODE_NONE;
         high_ff <= tsfh_pkg::HIGH_RESET;
         low_ff <= tsfh_pkg::LOW_RESET;
      end else if (csr_write) begin
         case (csr_index)
            tsfh_pkg::CSR_MODE: mode_ff <= csr_data[1:0];
            tsfh_pkg::CSR_HIGH: high_ff <= csr_data;
            tsfh_pkg::CSR_LOW: low_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) r_ff <= req_payload;
   end

   // first free slot
   logic [SW-1:0] free_idx;
   logic          free_any;
   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = tsfh_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!open_ff[i]) begin
            free_idx = SW'(i);
            free_any = 1'b1;
         end
      end
   end

   logic [7:0] sfull;
   logic [SW-1:0] s, ws;
   logic [7:0] g, cg, ng;
   logic [11:0] dlen;
   logic [FW-1:0] f0, f1, f2, f3;
   logic [FW:0] room;
   logic stale, q, up;

   always_comb begin
      sfull = r_ff.slot;
      s = sfull[SW-1:0];
      g = r_ff.generation;
      q = r_ff.queue_accepts;
      up = r_ff.link_up;
      cg = gen_ff[s];
      dlen = r_ff.frame_len - tsfh_pkg::PREFIX_BYTES;
      stale = !open_ff[s] && cg != 8'd0 && g != cg;
      f0 = fill_ff[s];
      f1 = f0 - ((r_ff.drained_before < f0) ? r_ff.drained_before : f0);
      room = {1'b0, tsfh_pkg::BUFFER_BYTES} - {1'b0, f1};
      f2 = f1 + FW'(dlen);
      f3 = f2 - ((r_ff.drained_after < f2) ? r_ff.drained_after : f2);
      ng = gen_ff[free_idx] + 8'd1;
      if (ng == 8'd0) ng = 8'd1;

      open_in = open_ff; rp_in = rp_ff; ps_in = ps_ff;
      gen_in = cg; fill_in = f0; wr_gen = 1'b0; wr_fill = 1'b0;
      ws = s;
      res = '0;
      res.status = tsfh_pkg::ST_OK;

      case (r_ff.command)
         tsfh_pkg::CMD_FRAME: begin
            if (mode_ff == tsfh_pkg::MODE_NONE) res.status = tsfh_pkg::ST_NO_MODE;
            else if (r_ff.frame_len < tsfh_pkg::PREFIX_BYTES ||
                     r_ff.frame_len > tsfh_pkg::MAX_PAYLOAD)
               res.status = tsfh_pkg::ST_BAD_LEN;
            else if (g == 8'd0) res.status = tsfh_pkg::ST_ZERO_GEN;
            else if (sfull >= 8'(tsfh_pkg::SLOTS)) res.status = tsfh_pkg::ST_BAD_SLOT;
            else if (r_ff.frame_type != tsfh_pkg::FT_DATA && dlen != 12'd0)
               res.status = tsfh_pkg::ST_CTRL_DATA;
            else begin
               case (r_ff.frame_type)
                  tsfh_pkg::FT_OPEN: begin
                     if (mode_ff == tsfh_pkg::MODE_LISTEN)
                        res.status = tsfh_pkg::ST_OPEN_LISTEN;
                     else if (open_ff[s]) res.status = tsfh_pkg::ST_DUP_OPEN;
                     else if (!r_ff.connect_ok) begin
                        if (q) begin
                           res.emit_kind = tsfh_pkg::EM_CLOSE;
                           res.emit_slot = s; res.emit_gen = g;
                        end else res.status = tsfh_pkg::ST_QUEUE;
                     end else begin
                        open_in[s] = 1'b1; rp_in[s] = 1'b0; ps_in[s] = 1'b0;
                        fill_in = '0; wr_fill = 1'b1;
                        gen_in = g; wr_gen = 1'b1;
                     end
                  end
                  tsfh_pkg::FT_DATA: begin
                     if (stale) ;
                     else if (!open_ff[s]) begin
                        if (q) begin
                           res.emit_kind = tsfh_pkg::EM_CLOSE;
                           res.emit_slot = s; res.emit_gen = g;
                        end else res.status = tsfh_pkg::ST_QUEUE;
                     end else if (g != cg || dlen == 12'd0) ;
                     else if (r_ff.fail_before || (!(room < {8'd0, dlen}) &&
                              r_ff.fail_after)) begin
                        open_in[s] = 1'b0; rp_in[s] = 1'b0; ps_in[s] = 1'b0;
                        fill_in = '0; wr_fill = 1'b1;
                        if (q) begin
                           res.emit_kind = tsfh_pkg::EM_CLOSE;
                           res.emit_slot = s; res.emit_gen = cg;
                        end
                        if (!up) res.status = tsfh_pkg::ST_LINK_DOWN;
                     end else if (room < {8'd0, dlen}) begin
                        fill_in = f1; wr_fill = 1'b1;
                        res.status = tsfh_pkg::ST_OVERFLOW;
                     end else begin
                        fill_in = f3; wr_fill = 1'b1;
                        if (!ps_ff[s] && f3 > high_ff) begin
                           if (q) begin
                              res.emit_kind = tsfh_pkg::EM_PAUSE;
                              res.emit_slot = s; res.emit_gen = cg;
                              ps_in[s] = 1'b1;
                           end else res.status = tsfh_pkg::ST_QUEUE;
                        end else if (ps_ff[s] && f3 < low_ff) begin
                           if (q) begin
                              res.emit_kind = tsfh_pkg::EM_RESUME;
                              res.emit_slot = s; res.emit_gen = cg;
                              ps_in[s] = 1'b0;
                           end else res.status = tsfh_pkg::ST_QUEUE;
                        end
                     end
                  end
                  tsfh_pkg::FT_CLOSE, tsfh_pkg::FT_PAUSE, tsfh_pkg::FT_RESUME: begin
                     if (!stale && open_ff[s] && g == cg) begin
                        if (r_ff.frame_type == tsfh_pkg::FT_CLOSE) begin
                           open_in[s] = 1'b0; rp_in[s] = 1'b0; ps_in[s] = 1'b0;
                           fill_in = '0; wr_fill = 1'b1;
                        end else rp_in[s] = (r_ff.frame_type == tsfh_pkg::FT_PAUSE);
                     end
                  end
                  default: res.status = tsfh_pkg::ST_UNKNOWN;
               endcase
            end
         end
         tsfh_pkg::CMD_ACCEPT: begin
            ws = free_idx;
            if (mode_ff != tsfh_pkg::MODE_LISTEN) res.status = tsfh_pkg::ST_NO_MODE;
            else if (!free_any) res.status = tsfh_pkg::ST_BAD_SLOT;
            else if (!up) res.status = tsfh_pkg::ST_LINK_DOWN;
            else begin
               gen_in = ng; wr_gen = 1'b1;
               fill_in = '0; wr_fill = 1'b1;
               rp_in[free_idx] = 1'b0; ps_in[free_idx] = 1'b0;
               if (q) begin
                  open_in[free_idx] = 1'b1;
                  res.emit_kind = tsfh_pkg::EM_OPEN;
                  res.emit_slot = free_idx; res.emit_gen = ng;
               end else res.status = tsfh_pkg::ST_QUEUE;
            end
         end
         tsfh_pkg::CMD_DRAIN: begin
            if (sfull >= 8'(tsfh_pkg::SLOTS)) res.status = tsfh_pkg::ST_BAD_SLOT;
            else if (open_ff[s]) begin
               if (!up) res.status = tsfh_pkg::ST_LINK_DOWN;
               if (r_ff.fail_before) begin
                  open_in[s] = 1'b0; rp_in[s] = 1'b0; ps_in[s] = 1'b0;
                  fill_in = '0; wr_fill = 1'b1;
                  if (q) begin
                     res.emit_kind = tsfh_pkg::EM_CLOSE;
                     res.emit_slot = s; res.emit_gen = cg;
                  end
               end else begin
                  fill_in = f1; wr_fill = 1'b1;
                  if (ps_ff[s] && f1 < low_ff && q) begin
                     res.emit_kind = tsfh_pkg::EM_RESUME;
                     res.emit_slot = s; res.emit_gen = cg;
                     ps_in[s] = 1'b0;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0; rp_ff <= '0; ps_ff <= '0;
         for (int i = 0; i < tsfh_pkg::SLOTS; i++) begin
            gen_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else if (cmd.execute) begin
         open_ff <= open_in; rp_ff <= rp_in; ps_ff <= ps_in;
         if (wr_gen) gen_ff[ws] <= gen_in;
         if (wr_fill) fill_ff[ws] <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) out_ff <= res;
   end

   assign rsp_payload = out_ff;
endmodule
`default_nettype wire

@@ rtl/tunnel_slot_frame_handler.sv @@
// Top level of the tunnel slot frame handler: controller plus datapath.
// Depends on tsfh_pkg, tsfh_if, tsfh_ctrl and tsfh_datapath.
`default_nettype none
// The block keeps a 16-slot table of tunnel connections (open flag,
// generation, remote pause, pause sent and buffer occupancy) in flip-flops
// and applies one request at a time: a remote frame, a local accept or a
// local drain. Each request gives exactly one result. A request is handled
// in steps: it is captured, then the slot entry is read, modified and
// written, then the result is presented and held until taken; the next
// request is accepted once the result has been taken. The user must write
// configuration registers (mode, high and low watermark) through the csr_
// port only while no request is in flight; the block does not enforce this.
module tunnel_slot_frame_handler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [18:0] csr_data,
   tsfh_req_if.sink         req,
   tsfh_rsp_if.source       rsp
);
   tsfh_pkg::cmd_type cmd;

   // The controller owns the handshakes; the datapath only sees commands.
   tsfh_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd(cmd)
   );

   tsfh_datapath u_datapath (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .cmd(cmd), .req_payload(req.payload), .rsp_payload(rsp.payload)
   );
endmodule
`default_nettype wire

@@ verif/tunnel_slot_frame_handler_tb.sv @@
// Self-checking testbench for tunnel_slot_frame_handler: directed table, then random traffic.
// Depends on tsfh_pkg and the tsfh_req_if / tsfh_rsp_if channel interfaces.
module tunnel_slot_frame_handler_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tsfh_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 6;
   localparam int RANDOM_ITEMS = 1950;
   localparam logic [18:0] FILL_MAX = 19'd262144;

   logic clock;
   logic reset;
   logic csr_write;
   logic [1:0] csr_index;
   logic [18:0] csr_data;

   tsfh_req_if req_ch ();
   tsfh_rsp_if rsp_ch ();

   tunnel_slot_frame_handler DUT (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req(req_ch), .rsp(rsp_ch)
   );

   // Free-running clock, 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Shadow copy of the slot table and the registers, updated as requests are accepted.
   logic        open_q   [SLOTS];
   logic [7:0]  gen_q    [SLOTS];
   logic        rpause_q [SLOTS];
   logic        psent_q  [SLOTS];
   logic [18:0] fill_q   [SLOTS];
   logic [1:0]  mode_q;
   logic [18:0] high_q;
   logic [18:0] low_q;
   rsp_type     emitted;

   rsp_type pending_rsp[$];
   int errors;
   int cycles;

   typedef struct {
      bit          is_csr;
      logic [1:0]  idx;
      logic [18:0] val;
      req_type     rq;
      bit          has_exp;
      rsp_type     exp;
   } plan_row;

   plan_row plan[$];

   // ------------------------------------------------------------------
   // Slot table predictor.
   // ------------------------------------------------------------------
   function automatic bit send_partner(logic [2:0] kind, int s, logic [7:0] g, logic q);
      if (!q) return 1'b0;
      emitted.emit_kind = kind;
      emitted.emit_slot = s[3:0];
      emitted.emit_gen  = g;
      return 1'b1;
   endfunction

   function automatic void clear_slot(int s);
      open_q[s]   = 1'b0;
      rpause_q[s] = 1'b0;
      psent_q[s]  = 1'b0;
      fill_q[s]   = '0;
   endfunction

   // Drains larger than the occupancy simply empty the buffer.
   function automatic void drain_slot(int s, logic [18:0] n);
      fill_q[s] = fill_q[s] - ((n < fill_q[s]) ? n : fill_q[s]);
   endfunction

   // A failed downstream write closes the slot and tells the partner if the queue allows.
   function automatic logic [3:0] close_on_failure(int s, logic q, logic up);
      clear_slot(s);
      void'(send_partner(EM_CLOSE, s, gen_q[s], q));
      return up ? ST_OK : ST_LINK_DOWN;
   endfunction

   function automatic logic [3:0] apply_frame(req_type r);
      int s;
      logic [11:0] dlen;
      bit stale;
      if (mode_q == MODE_NONE) return ST_NO_MODE;
      if (r.frame_len < PREFIX_BYTES || r.frame_len > MAX_PAYLOAD) return ST_BAD_LEN;
      dlen = r.frame_len - PREFIX_BYTES;
      if (r.generation == 8'd0) return ST_ZERO_GEN;
      if (r.slot >= SLOTS) return ST_BAD_SLOT;
      s = r.slot;
      if (r.frame_type != FT_DATA && dlen != 0) return ST_CTRL_DATA;
      stale = !open_q[s] && gen_q[s] != 8'd0 && r.generation != gen_q[s];
      case (r.frame_type)
         FT_OPEN: begin
            // Mode three counts as connect side, so only listen side refuses.
            if (mode_q == MODE_LISTEN) return ST_OPEN_LISTEN;
            if (open_q[s]) return ST_DUP_OPEN;
            if (!r.connect_ok)
               return send_partner(EM_CLOSE, s, r.generation, r.queue_accepts) ?
                      ST_OK : ST_QUEUE;
            clear_slot(s);
            open_q[s] = 1'b1;
            gen_q[s]  = r.generation;
            return ST_OK;
         end
         FT_DATA: begin
            if (stale) return ST_OK;
            if (!open_q[s])
               return send_partner(EM_CLOSE, s, r.generation, r.queue_accepts) ?
                      ST_OK : ST_QUEUE;
            if (r.generation != gen_q[s] || dlen == 0) return ST_OK;
            drain_slot(s, r.drained_before);
            if (r.fail_before) return close_on_failure(s, r.queue_accepts, r.link_up);
            if (BUFFER_BYTES - fill_q[s] < {7'd0, dlen}) return ST_OVERFLOW;
            fill_q[s] = fill_q[s] + {7'd0, dlen};
            drain_slot(s, r.drained_after);
            if (r.fail_after) return close_on_failure(s, r.queue_accepts, r.link_up);
            // Hysteresis: the occupancy change stays even if the queue refuses.
            if (!psent_q[s] && fill_q[s] > high_q) begin
               if (!send_partner(EM_PAUSE, s, gen_q[s], r.queue_accepts)) return ST_QUEUE;
               psent_q[s] = 1'b1;
            end else if (psent_q[s] && fill_q[s] < low_q) begin
               if (!send_partner(EM_RESUME, s, gen_q[s], r.queue_accepts)) return ST_QUEUE;
               psent_q[s] = 1'b0;
            end
            return ST_OK;
         end
         FT_CLOSE, FT_PAUSE, FT_RESUME: begin
            if (stale || !open_q[s] || r.generation != gen_q[s]) return ST_OK;
            if (r.frame_type == FT_CLOSE) clear_slot(s);
            else rpause_q[s] = (r.frame_type == FT_PAUSE);
            return ST_OK;
         end
         default: return ST_UNKNOWN;
      endcase
   endfunction

   function automatic logic [3:0] apply_accept(req_type r);
      int s;
      s = 0;
      if (mode_q != MODE_LISTEN) return ST_NO_MODE;
      while (s < SLOTS && open_q[s]) s++;
      if (s >= SLOTS) return ST_BAD_SLOT;
      if (!r.link_up) return ST_LINK_DOWN;
      clear_slot(s);
      open_q[s] = 1'b1;
      gen_q[s]  = gen_q[s] + 8'd1;
      if (gen_q[s] == 8'd0) gen_q[s] = 8'd1;
      if (!send_partner(EM_OPEN, s, gen_q[s], r.queue_accepts)) begin
         // The slot closes again but keeps its advanced generation.
         clear_slot(s);
         return ST_QUEUE;
      end
      return ST_OK;
   endfunction

   function automatic logic [3:0] apply_drain(req_type r);
      int s;
      if (r.slot >= SLOTS) return ST_BAD_SLOT;
      s = r.slot;
      if (!open_q[s]) return ST_OK;
      drain_slot(s, r.drained_before);
      if (r.fail_before) return close_on_failure(s, r.queue_accepts, r.link_up);
      // A refused RESUME leaves the pause flag set and is not an error.
      if (psent_q[s] && fill_q[s] < low_q)
         if (send_partner(EM_RESUME, s, gen_q[s], r.queue_accepts)) psent_q[s] = 1'b0;
      return r.link_up ? ST_OK : ST_LINK_DOWN;
   endfunction

   function automatic rsp_type predict_response(req_type r);
      logic [3:0] st;
      emitted = '0;
      st = ST_OK;
      case (r.command)
         CMD_FRAME:  st = apply_frame(r);
         CMD_ACCEPT: st = apply_accept(r);
         CMD_DRAIN:  st = apply_drain(r);
         default:    st = ST_OK;
      endcase
      emitted.status = st;
      return emitted;
   endfunction

   function automatic req_type make_req(logic [1:0] cmd, logic [2:0] ft, logic [7:0] slot,
                                        logic [7:0] g, logic [11:0] len, int conn,
                                        int q, int db, int da,
                                        int fb, int fa, int up);
      req_type r;
      r.command = cmd;          r.frame_type = ft;
      r.slot = slot;            r.generation = g;
      r.frame_len = len;        r.connect_ok = conn[0];
      r.queue_accepts = q[0];   r.drained_before = db[18:0];
      r.drained_after = da[18:0]; r.fail_before = fb[0];
      r.fail_after = fa[0];     r.link_up = up[0];
      return r;
   endfunction

   function automatic rsp_type make_rsp(logic [3:0] st, logic [2:0] k, int s, int g);
      rsp_type x;
      x.status = st; x.emit_kind = k; x.emit_slot = s[3:0]; x.emit_gen = g[7:0];
      return x;
   endfunction

   // Mostly short gaps, some long ones.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [18:0] pick_count(bit wide);
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return FILL_MAX;
      if (roll == 1) return '0;
      if (wide || roll < 4) return 19'($urandom_range(0, 262144));
      return 19'($urandom_range(0, 700));
   endfunction

   // Random request. Most are requests on in-range slots, mostly with the slot's current generation;
   // the rest is noise over the full field widths, except the drain counts, drawn from 0 to 262144.
   function automatic req_type random_req();
      req_type r;
      logic [95:0] noise;
      int roll;
      int s;
      noise = {$urandom, $urandom, $urandom};
      r = noise[$bits(req_type)-1:0];
      r.drained_before = 19'($urandom_range(0, 262144));
      r.drained_after  = 19'($urandom_range(0, 262144));
      if ($urandom_range(0, 99) < 12) return r;
      s = $urandom_range(0, SLOTS - 1);
      r.slot = 8'(s);
      r.generation = ($urandom_range(0, 99) < 75 && gen_q[s] != 0) ? gen_q[s] :
                     8'($urandom_range(1, 255));
      r.connect_ok    = $urandom_range(0, 9) != 0;
      r.queue_accepts = $urandom_range(0, 9) != 0;
      r.fail_before   = $urandom_range(0, 39) == 0;
      r.fail_after    = $urandom_range(0, 39) == 0;
      r.link_up       = $urandom_range(0, 19) != 0;
      r.drained_before = pick_count(1'b0);
      r.drained_after  = pick_count(1'b0);
      r.frame_len = PREFIX_BYTES;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         r.command = CMD_FRAME;
         roll = $urandom_range(0, 99);
         if (roll < 50) begin
            r.frame_type = FT_DATA;
            r.frame_len = 12'($urandom_range(2, 1024));
         end else if (roll < 68) r.frame_type = FT_OPEN;
         else if (roll < 78) r.frame_type = FT_CLOSE;
         else if (roll < 88) r.frame_type = FT_PAUSE;
         else if (roll < 97) r.frame_type = FT_RESUME;
         else r.frame_type = 3'($urandom_range(5, 7));
      end else if (roll < 72) r.command = CMD_ACCEPT;
      else if (roll < 97) begin
         r.command = CMD_DRAIN;
         r.drained_before = pick_count(1'b1);
      end else r.command = 2'd3;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Sender side.
   // ------------------------------------------------------------------
   task automatic send_request(req_type r, bit has_exp, rsp_type exp, int gap);
      rsp_type predicted;
      req_ch.valid   <= 1'b1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      predicted = predict_response(r);
      pending_rsp.push_back(has_exp ? exp : predicted);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off until every expected result has arrived, then let the pipeline settle.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [18:0] val);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_MODE: mode_q = val[1:0];
         CSR_HIGH: high_q = val;
         CSR_LOW:  low_q  = val;
         default: ;
      endcase
   endtask

   task automatic add_req(req_type r);
      plan_row row;
      row = '{default: '0};
      row.rq = r;
      plan.push_back(row);
   endtask

   task automatic add_checked(req_type r, rsp_type exp);
      plan_row row;
      row = '{default: '0};
      row.rq = r;
      row.has_exp = 1'b1;
      row.exp = exp;
      plan.push_back(row);
   endtask

   task automatic add_csr(logic [1:0] idx, logic [18:0] val);
      plan_row row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.idx = idx;
      row.val = val;
      plan.push_back(row);
   endtask

   // ------------------------------------------------------------------
   // Receiver side: random back-pressure; in every fourth window of the cycle
   // count no new stall starts, so that results are also taken without any stall.
   // ------------------------------------------------------------------
   int stall_left;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         if ((cycles / 500) % 4 != 0 && $urandom_range(0, 4) == 0) stall_left <= pick_gap();
      end
   end

   // Compare every accepted result with the oldest outstanding expectation.
   always @(posedge clock) begin
      rsp_type exp;
      rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %p", got);
         end else begin
            exp = pending_rsp.pop_front();
            if (got.status !== exp.status || got.emit_kind !== exp.emit_kind ||
                got.emit_slot !== exp.emit_slot || got.emit_gen !== exp.emit_gen) begin
               errors++;
               if (errors <= 10)
                  $display({"response mismatch: status %0d/%0d kind %0d/%0d ",
                            "slot %0d/%0d gen %0d/%0d (expected/actual)"},
                           exp.status, got.status, exp.emit_kind, got.emit_kind,
                           exp.emit_slot, got.emit_slot, exp.emit_gen, got.emit_gen);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      int sent;
      int phase_items;
      rsp_type none_rsp;
      errors = 0;
      cycles = 0;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_MODE;
      csr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      mode_q = MODE_NONE;
      high_q = HIGH_RESET;
      low_q  = LOW_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         clear_slot(i);
         gen_q[i] = '0;
      end
      none_rsp = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Right after reset there is no tunnel mode.
      add_checked(make_req(CMD_FRAME, FT_DATA, 8'd0, 8'd1, 12'd10, 1, 1, 0, 0, 0, 0, 1),
                  make_rsp(ST_NO_MODE, EM_NONE, 0, 0));
      add_checked(make_req(CMD_ACCEPT, FT_OPEN, 8'd0, 8'd1, 12'd2, 1, 1, 0, 0, 0, 0, 1),
                  make_rsp(ST_NO_MODE, EM_NONE, 0, 0));
      add_checked(make_req(CMD_DRAIN, FT_OPEN, 8'd255, 8'd1, 12'd2, 1, 1, 5, 0, 0, 0, 1),
                  make_rsp(ST_BAD_SLOT, EM_NONE, 0, 0));
      add_checked(make_req(2'd3, 3'd7, 8'hFF, 8'hFF, 12'hFFF, 1, 1, '1, '1, 1, 1, 1),
                  make_rsp(ST_OK, EM_NONE, 0, 0));
      // Connect side: the header checks in order.
      add_csr(CSR_MODE, 19'd1);
      add_checked(make_req(CMD_FRAME, FT_OPEN, 8'd0, 8'd5, 12'd1, 1, 1, 0, 0, 0, 0, 1),
                  make_rsp(ST_BAD_LEN, EM_NONE, 0, 0));
      add_checked(make_req(CMD_FRAME, FT_DATA, 8'd0, 8'd5, 12'd4095, 1, 1, 0, 0, 0, 0, 1),
                  make_rsp(ST_BAD_LEN, EM_NONE, 0, 0));
      add_checked(make_req(CMD_FRAME, FT_OPEN, 8'd0, 8'd0, 12'd2, 1, 1, 0, 0, 0, 0, 1),
                  make_rsp(ST_ZERO_GEN, EM_NONE, 0, 0));
      add_checked(make_req(CMD_FRAME, FT_OPEN, 8'd255, 8'd5, 12'd2, 1, 1, 0, 0, 0, 0, 1),
                  make_rsp(ST_BAD_SLOT, EM_NONE, 0, 0));
      add_checked(make_req(CMD_FRAME, FT_CLOSE, 8'd0, 8'd5, 12'd3, 1, 1, 0, 0, 0, 0, 1),
                  make_rsp(ST_CTRL_DATA, EM_NONE, 0, 0));
      add_checked(make_req(CMD_FRAME, 3'd7, 8'd0, 8'd5, 12'd2, 1, 1, 0, 0, 0, 0, 1),
                  make_rsp(ST_UNKNOWN, EM_NONE, 0, 0));
      // Open, duplicate open, failed outbound connect with and without queue room.
      add_checked(make_req(CMD_FRAME, FT_OPEN, 8'd0, 8'd5, 12'd2, 1, 1, 0, 0, 0, 0, 1),
                  make_rsp(ST_OK, EM_NONE, 0, 0));
      add_checked(make_req(CMD_FRAME, FT_OPEN, 8'd0, 8'd5, 12'd2, 1, 1, 0, 0, 0, 0, 1),
                  make_rsp(ST_DUP_OPEN, EM_NONE, 0, 0));
      add_checked(make_req(CMD_FRAME, FT_OPEN, 8'd1, 8'd9, 12'd2, 0, 1, 0, 0, 0, 0, 1),
                  make_rsp(ST_OK, EM_CLOSE, 1, 9));
      add_checked(make_req(CMD_FRAME, FT_OPEN, 8'd1, 8'd9, 12'd2, 0, 0, 0, 0, 0, 0, 1),
                  make_rsp(ST_QUEUE, EM_NONE, 0, 0));
      // Data flow, write failure, data on a closed slot, clamped drain, remote pause.
      add_req(make_req(CMD_FRAME, FT_DATA, 8'd0, 8'd5, 12'd1024, 1, 1, 0, 0, 0, 0, 1));
      add_req(make_req(CMD_FRAME, FT_DATA, 8'd0, 8'd5, 12'd1024, 1, 0, '1, 0, 0, 0, 1));
      add_req(make_req(CMD_FRAME, FT_PAUSE, 8'd0, 8'd5, 12'd2, 1, 1, 0, 0, 0, 0, 1));
      add_req(make_req(CMD_DRAIN, FT_OPEN, 8'd0, 8'd5, 12'd2, 1, 1, FILL_MAX, 0, 0, 0, 0));
      add_checked(make_req(CMD_FRAME, FT_DATA, 8'd2, 8'd3, 12'd20, 1, 1, 0, 0, 0, 0, 1),
                  make_rsp(ST_OK, EM_CLOSE, 2, 3));
      add_req(make_req(CMD_FRAME, FT_DATA, 8'd0, 8'd5, 12'd500, 1, 1, 0, 0, 1, 0, 0));
      // Listen side: open refused, accept with link down, refused queue, success.
      add_csr(CSR_MODE, 19'(MODE_LISTEN));
      add_checked(make_req(CMD_FRAME, FT_OPEN, 8'd3, 8'd7, 12'd2, 1, 1, 0, 0, 0, 0, 1),
                  make_rsp(ST_OPEN_LISTEN, EM_NONE, 0, 0));
      add_req(make_req(CMD_ACCEPT, FT_OPEN, 8'd0, 8'd0, 12'd0, 1, 1, 0, 0, 0, 0, 0));
      add_req(make_req(CMD_ACCEPT, FT_OPEN, 8'd0, 8'd0, 12'd0, 1, 0, 0, 0, 0, 0, 1));
      add_req(make_req(CMD_ACCEPT, FT_OPEN, 8'd0, 8'd0, 12'd0, 1, 1, 0, 0, 0, 0, 1));
      // Mode three acts as connect side.
      add_csr(CSR_MODE, 19'd3);
      add_req(make_req(CMD_FRAME, FT_OPEN, 8'd15, 8'd255, 12'd2, 1, 1, 0, 0, 0, 0, 1));

      foreach (plan[i]) begin
         if (plan[i].is_csr) write_csr(plan[i].idx, plan[i].val);
         else send_request(plan[i].rq, plan[i].has_exp, plan[i].exp, pick_gap());
      end

      // Random part in phases of register settings, the extremes among them.
      sent = 0;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_MODE, 19'd1);
               write_csr(CSR_HIGH, HIGH_RESET);
               write_csr(CSR_LOW, LOW_RESET);
            end
            1: begin
               write_csr(CSR_MODE, 19'(MODE_LISTEN));
               write_csr(CSR_HIGH, 19'd2000);
               write_csr(CSR_LOW, 19'd500);
            end
            2: begin
               write_csr(CSR_MODE, 19'd3);
               write_csr(CSR_HIGH, 19'd0);
               write_csr(CSR_LOW, 19'd0);
            end
            3: begin
               write_csr(CSR_MODE, 19'd1);
               write_csr(CSR_HIGH, FILL_MAX);
               write_csr(CSR_LOW, FILL_MAX);
            end
            4: write_csr(CSR_MODE, 19'(MODE_NONE));
            5: begin
               write_csr(CSR_MODE, 19'(MODE_LISTEN));
               write_csr(CSR_HIGH, 19'($urandom_range(0, 262144)));
               write_csr(CSR_LOW, 19'($urandom_range(0, 262144)));
            end
            6: begin
               write_csr(CSR_MODE, 19'd1);
               write_csr(CSR_HIGH, 19'd4000);
               write_csr(CSR_LOW, 19'd3000);
            end
            default: begin
               write_csr(CSR_MODE, 19'd2);
               write_csr(CSR_HIGH, 19'($urandom_range(1000, 8000)));
               write_csr(CSR_LOW, 19'($urandom_range(0, 1000)));
            end
         endcase
         phase_items = (phase == 4) ? 60 : (RANDOM_ITEMS - 60) / 7;
         for (int n = 0; n < phase_items; n++) begin
            // The opening stretch of every phase runs without sender gaps.
            send_request(random_req(), 1'b0, none_rsp, (n < 40) ? 0 : pick_gap());
            sent++;
         end
      end

      wait_idle();
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
